// ----- rtl/core/gasa_pkg.sv -----
// ----------------------------------------------------------------------------
// gasa_pkg
// Shared types and constants of the glyph atlas shelf allocator.
// ----------------------------------------------------------------------------
package gasa_pkg;

    localparam int ATLAS_SIZE  = 1024;
    localparam int MAX_SHELVES = 32;
    localparam int MAX_GLYPHS  = 256;

    localparam int SH_AW = $clog2(MAX_SHELVES);
    localparam int GL_AW = $clog2(MAX_GLYPHS);
    localparam int POS_W = 10;
    localparam int ROW_W = $clog2(ATLAS_SIZE) + 1;
    localparam int KEY_W = 29;
    localparam int PLC_W = 2 * POS_W + 16;

    localparam logic [1:0] ST_FOUND  = 2'd0;
    localparam logic [1:0] ST_PLACED = 2'd1;
    localparam logic [1:0] ST_NOROOM = 2'd2;

    typedef struct packed {
        logic [7:0]  px_size;
        logic [20:0] char_code;
        logic [7:0]  glyph_width;
        logic [7:0]  glyph_height;
    } t_req;

    typedef struct packed {
        logic [1:0]       status;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic [7:0]       rect_width;
        logic [7:0]       rect_height;
    } t_res;

    typedef struct packed {
        logic [7:0]       size;
        logic [POS_W-1:0] top;
        logic [ROW_W-1:0] fill;
    } t_shelf;

endpackage

// ----- rtl/core/glyph_atlas_shelf_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// glyph_atlas_shelf_allocator_unit
// Shelf-packing allocator for a glyph texture atlas.
// ----------------------------------------------------------------------------
// One lookup at a time. A lookup scans the stored glyphs one per cycle (one
// read of the glyph table each), then on a miss scans the open shelves one per
// cycle, then writes back. The single read port of each table is what makes
// the scans step through one entry at a time.
// The result sits in an output register, and the next lookup is taken while it
// waits. No clearing pass is needed after reset.
module glyph_atlas_shelf_allocator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // px_size, char_code, glyph_width, glyph_height
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata   // status, pos_x, pos_y, rect_width, rect_height
);
    import gasa_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_GSCAN = 3'd1;
    localparam logic [2:0] S_SSCAN = 3'd2;
    localparam logic [2:0] S_DONE  = 3'd3;

    logic [2:0]       r_state;
    t_req             r_req;
    logic [KEY_W-1:0] r_key;
    logic [GL_AW:0]   r_ecount;
    logic [SH_AW:0]   r_scount;
    logic [ROW_W-1:0] r_rows;
    logic [GL_AW:0]   r_gidx;
    logic [SH_AW:0]   r_sidx;
    logic             r_rdv;
    t_res             r_res;
    logic             r_ovalid;
    t_res             r_out;

    logic                   g_we;
    logic [KEY_W+PLC_W-1:0] g_wdata;
    logic [KEY_W+PLC_W-1:0] g_rdata;
    logic                   s_we;
    logic [SH_AW-1:0]       s_waddr;
    t_shelf                 s_wdata;
    t_shelf                 s_rdata;

    logic             in_fire;
    logic [ROW_W:0]   fit_sum;
    logic [ROW_W:0]   new_rows;
    logic [POS_W-1:0] g_x;
    logic [POS_W-1:0] g_y;

    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);

    gasa_glyph_table u_glyph (
        .i_clk  (i_clk),
        .i_we   (g_we),
        .i_waddr(r_ecount[GL_AW-1:0]),
        .i_wdata(g_wdata),
        .i_raddr(r_gidx[GL_AW-1:0]),
        .o_rdata(g_rdata)
    );

    gasa_shelf_table u_shelf (
        .i_clk  (i_clk),
        .i_we   (s_we),
        .i_waddr(s_waddr),
        .i_wdata(s_wdata),
        .i_raddr(r_sidx[SH_AW-1:0]),
        .o_rdata(s_rdata)
    );

    assign fit_sum  = {1'b0, s_rdata.fill} + (ROW_W+1)'(r_req.glyph_width);
    assign new_rows = {1'b0, r_rows} + (ROW_W+1)'(r_req.px_size);
    assign g_x = g_rdata[PLC_W-1 -: POS_W];
    assign g_y = g_rdata[PLC_W-POS_W-1 -: POS_W];

    always_comb begin
        g_we    = 1'b0;
        g_wdata = '0;
        s_we    = 1'b0;
        s_waddr = r_scount[SH_AW-1:0];
        s_wdata = '0;
        if (r_state == S_SSCAN && r_rdv && r_sidx <= r_scount
                && s_rdata.size == r_req.px_size
                && fit_sum <= (ROW_W+1)'(ATLAS_SIZE)) begin
            g_we    = 1'b1;
            g_wdata = {r_key, s_rdata.fill[POS_W-1:0], s_rdata.top,
                       r_req.glyph_width, r_req.glyph_height};
            s_we    = 1'b1;
            s_waddr = r_sidx[SH_AW-1:0] - 1'b1;
            s_wdata.size = s_rdata.size;
            s_wdata.top  = s_rdata.top;
            s_wdata.fill = fit_sum[ROW_W-1:0] + 1'b1;
        end else if (r_state == S_SSCAN && (!r_rdv || r_sidx > r_scount)
                && !(r_sidx <= r_scount && r_rdv)) begin
            if (r_sidx > r_scount && r_scount < (SH_AW+1)'(MAX_SHELVES)
                    && new_rows <= (ROW_W+1)'(ATLAS_SIZE)) begin
                g_we    = 1'b1;
                g_wdata = {r_key, {POS_W{1'b0}}, r_rows[POS_W-1:0],
                           r_req.glyph_width, r_req.glyph_height};
                s_we    = 1'b1;
                s_wdata.size = r_req.px_size;
                s_wdata.top  = r_rows[POS_W-1:0];
                s_wdata.fill = ROW_W'(r_req.glyph_width) + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ecount <= '0;
            r_scount <= '0;
            r_rows   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && m_axis_tready && r_state != S_DONE) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_req.px_size      <= s_axis_tdata[7:0];
                        r_req.char_code    <= s_axis_tdata[28:8];
                        r_req.glyph_width  <= s_axis_tdata[36:29];
                        r_req.glyph_height <= s_axis_tdata[44:37];
                        r_key   <= {s_axis_tdata[7:0], s_axis_tdata[28:8]};
                        r_gidx  <= '0;
                        r_rdv   <= 1'b0;
                        r_state <= S_GSCAN;
                    end
                end
                S_GSCAN: begin
                    r_gidx <= r_gidx + 1'b1;
                    if (r_rdv && g_rdata[KEY_W+PLC_W-1 -: KEY_W] == r_key) begin
                        r_res   <= {ST_FOUND, g_x, g_y, g_rdata[15:0]};
                        r_state <= S_DONE;
                    end else if (r_gidx >= r_ecount) begin
                        if (r_ecount >= (GL_AW+1)'(MAX_GLYPHS)
                                || 11'(r_req.glyph_width) > 11'(ATLAS_SIZE)) begin
                            r_res   <= {ST_NOROOM, 36'd0};
                            r_state <= S_DONE;
                        end else begin
                            r_sidx  <= '0;
                            r_rdv   <= 1'b0;
                            r_state <= S_SSCAN;
                        end
                    end else begin
                        r_rdv <= 1'b1;
                    end
                end
                S_SSCAN: begin
                    r_sidx <= r_sidx + 1'b1;
                    r_rdv  <= 1'b1;
                    if (g_we) begin
                        r_ecount <= r_ecount + 1'b1;
                        r_res    <= {ST_PLACED, g_wdata[PLC_W-1:0]};
                        r_state  <= S_DONE;
                        if (s_waddr == r_scount[SH_AW-1:0] && r_sidx > r_scount) begin
                            r_scount <= r_scount + 1'b1;
                            r_rows   <= new_rows[ROW_W-1:0];
                        end
                    end else if (r_sidx > r_scount) begin
                        r_res   <= {ST_NOROOM, 36'd0};
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_out    <= r_res;
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {2'b00, r_out.rect_height, r_out.rect_width, r_out.pos_y,
                            r_out.pos_x, r_out.status};

endmodule

// ----- rtl/core/gasa_glyph_table.sv -----
// ----------------------------------------------------------------------------
// gasa_glyph_table
// Stored glyph keys and rectangles; one synchronous read port, one write port.
// ----------------------------------------------------------------------------
module gasa_glyph_table (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [gasa_pkg::GL_AW-1:0]              i_waddr,
    input  logic [gasa_pkg::KEY_W+gasa_pkg::PLC_W-1:0] i_wdata,
    input  logic [gasa_pkg::GL_AW-1:0]              i_raddr,
    output logic [gasa_pkg::KEY_W+gasa_pkg::PLC_W-1:0] o_rdata
);
    import gasa_pkg::*;

    logic [KEY_W+PLC_W-1:0] r_mem [MAX_GLYPHS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- rtl/core/gasa_shelf_table.sv -----
// ----------------------------------------------------------------------------
// gasa_shelf_table
// Shelf size, top row and fill; one synchronous read port, one write port.
// ----------------------------------------------------------------------------
module gasa_shelf_table (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [gasa_pkg::SH_AW-1:0] i_waddr,
    input  gasa_pkg::t_shelf           i_wdata,
    input  logic [gasa_pkg::SH_AW-1:0] i_raddr,
    output gasa_pkg::t_shelf           o_rdata
);
    import gasa_pkg::*;

    t_shelf r_mem [MAX_SHELVES];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- dv/glyph_atlas_shelf_allocator_checker.sv -----
// ----------------------------------------------------------------------------
// glyph_atlas_shelf_allocator_checker
// Watches both stream channels of the allocator, models the shelf and glyph
// tables, and compares every result word with the predicted placement.
// ----------------------------------------------------------------------------
module glyph_atlas_shelf_allocator_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [47:0] i_s_tdata,  // px_size, char_code, glyph_width, glyph_height
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [39:0] i_m_tdata,  // status, pos_x, pos_y, rect_width, rect_height
    output int          o_fail_count,
    output int          o_pending,
    output int          o_found_count,
    output int          o_noroom_count
);
    import gasa_pkg::*;

    int unsigned shelf_height [MAX_SHELVES];
    int unsigned shelf_row    [MAX_SHELVES];
    int unsigned shelf_used   [MAX_SHELVES];
    int unsigned open_shelves;
    int unsigned rows_taken;
    int unsigned glyph_key    [MAX_GLYPHS];
    t_res        glyph_rect   [MAX_GLYPHS];
    int unsigned stored_glyphs;
    t_res        placement_q  [$];

    function automatic t_res make_rect(logic [1:0] st, int unsigned x, int unsigned y,
                                       int unsigned w, int unsigned h);
        t_res r;
        r.status      = st;
        r.pos_x       = x[POS_W-1:0];
        r.pos_y       = y[POS_W-1:0];
        r.rect_width  = w[7:0];
        r.rect_height = h[7:0];
        return r;
    endfunction

    function automatic t_res place_glyph(t_req q);
        int unsigned key;
        int unsigned w;
        int unsigned x;
        t_res        r;
        key = {3'd0, q.px_size, q.char_code};
        w   = q.glyph_width;
        for (int i = 0; i < stored_glyphs; i++) begin
            if (glyph_key[i] == key) begin
                r        = glyph_rect[i];
                r.status = ST_FOUND;
                return r;
            end
        end
        if (stored_glyphs >= MAX_GLYPHS || w > ATLAS_SIZE)
            return make_rect(ST_NOROOM, 0, 0, 0, 0);
        for (int i = 0; i < open_shelves; i++) begin
            if (shelf_height[i] == q.px_size && shelf_used[i] + w <= ATLAS_SIZE) begin
                x = shelf_used[i];
                shelf_used[i] = x + w + 1;
                r = make_rect(ST_PLACED, x, shelf_row[i], w, q.glyph_height);
                glyph_key[stored_glyphs]  = key;
                glyph_rect[stored_glyphs] = r;
                stored_glyphs++;
                return r;
            end
        end
        if (open_shelves >= MAX_SHELVES || rows_taken + q.px_size > ATLAS_SIZE)
            return make_rect(ST_NOROOM, 0, 0, 0, 0);
        shelf_height[open_shelves] = q.px_size;
        shelf_row[open_shelves]    = rows_taken;
        shelf_used[open_shelves]   = w + 1;
        r = make_rect(ST_PLACED, 0, rows_taken, w, q.glyph_height);
        open_shelves++;
        rows_taken += q.px_size;
        glyph_key[stored_glyphs]  = key;
        glyph_rect[stored_glyphs] = r;
        stored_glyphs++;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_req q;
        t_res got;
        t_res want;
        if (!i_rst_n) begin
            open_shelves  = 0;
            rows_taken    = 0;
            stored_glyphs = 0;
            placement_q.delete();
            o_fail_count   <= 0;
            o_found_count  <= 0;
            o_noroom_count <= 0;
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                q.px_size      = i_s_tdata[7:0];
                q.char_code    = i_s_tdata[28:8];
                q.glyph_width  = i_s_tdata[36:29];
                q.glyph_height = i_s_tdata[44:37];
                placement_q.push_back(place_glyph(q));
            end
            if (i_m_tvalid && i_m_tready) begin
                got.status      = i_m_tdata[1:0];
                got.pos_x       = i_m_tdata[11:2];
                got.pos_y       = i_m_tdata[21:12];
                got.rect_width  = i_m_tdata[29:22];
                got.rect_height = i_m_tdata[37:30];
                if (placement_q.size() == 0) begin
                    $error("result word with no lookup outstanding: %h", i_m_tdata);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = placement_q.pop_front();
                    if (want.status == ST_FOUND) o_found_count <= o_found_count + 1;
                    if (want.status == ST_NOROOM) o_noroom_count <= o_noroom_count + 1;
                    if (got != want) begin
                        if (got.status != want.status)
                            $error("status: expected %0d, got %0d", want.status, got.status);
                        if (got.pos_x != want.pos_x)
                            $error("pos_x: expected %0d, got %0d", want.pos_x, got.pos_x);
                        if (got.pos_y != want.pos_y)
                            $error("pos_y: expected %0d, got %0d", want.pos_y, got.pos_y);
                        if (got.rect_width != want.rect_width)
                            $error("rect_width: expected %0d, got %0d",
                                   want.rect_width, got.rect_width);
                        if (got.rect_height != want.rect_height)
                            $error("rect_height: expected %0d, got %0d",
                                   want.rect_height, got.rect_height);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
        o_pending <= placement_q.size();
    end

endmodule

// ----- dv/tb_glyph_atlas_shelf_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// tb_glyph_atlas_shelf_allocator_unit
// Drives directed and random glyph lookups into the atlas allocator under
// varying stream back-pressure; the checker scores every result word.
// ----------------------------------------------------------------------------
module tb_glyph_atlas_shelf_allocator_unit;
    import gasa_pkg::*;

    localparam int RANDOM_LOOKUPS = 1800;
    localparam int CYCLE_LIMIT    = 4000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    int          fail_count;
    int          pending;
    int          found_count;
    int          noroom_count;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          lookups_sent = 0;
    int          cycle_count = 0;

    always #5 i_clk = ~i_clk;

    glyph_atlas_shelf_allocator_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    glyph_atlas_shelf_allocator_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_tvalid     (s_axis_tvalid),
        .i_s_tready     (s_axis_tready),
        .i_s_tdata      (s_axis_tdata),
        .i_m_tvalid     (m_axis_tvalid),
        .i_m_tready     (m_axis_tready),
        .i_m_tdata      (m_axis_tdata),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_found_count  (found_count),
        .o_noroom_count (noroom_count)
    );

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_glyph_atlas_shelf_allocator_unit: FAIL");
            $finish;
        end
    end

    task automatic send_lookup(input logic [7:0] size, input logic [20:0] code,
                               input logic [7:0] w, input logic [7:0] h);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, h, w, code, size};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        lookups_sent++;
    endtask

    task automatic send_random_lookup();
        logic [7:0]  size;
        logic [20:0] code;
        size = ($urandom_range(99) < 75) ? 8'($urandom_range(5) * 7) : 8'($urandom);
        code = ($urandom_range(99) < 65) ? 21'($urandom_range(40)) : 21'($urandom);
        send_lookup(size, code, 8'($urandom), 8'($urandom));
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_idle_pct = 17;
        recv_idle_pct = 56;
        // extremes, zero size, hits, shelf wrap and tall glyphs
        send_lookup(8'd0, 21'd0, 8'd0, 8'd0);
        send_lookup(8'd0, 21'd0, 8'd9, 8'd9);
        send_lookup(8'd255, 21'h1FFFFF, 8'd255, 8'd255);
        send_lookup(8'd255, 21'h10FFFF, 8'd255, 8'd0);
        send_lookup(8'd255, 21'd65, 8'd255, 8'd255);
        send_lookup(8'd255, 21'd66, 8'd255, 8'd200);
        send_lookup(8'd255, 21'd67, 8'd255, 8'd1);
        send_lookup(8'd255, 21'h1FFFFF, 8'd1, 8'd1);
        send_lookup(8'd1, 21'h0AAAAA, 8'd170, 8'd85);
        send_lookup(8'd1, 21'h155555, 8'd85, 8'd170);
        send_lookup(8'd0, 21'd7, 8'd255, 8'd255);
        send_lookup(8'd255, 21'd100, 8'd4, 8'd4);
        send_lookup(8'd255, 21'd101, 8'd4, 8'd4);
        send_lookup(8'd255, 21'd102, 8'd4, 8'd4);
        send_lookup(8'd255, 21'd103, 8'd4, 8'd4);
        send_lookup(8'd1, 21'h0AAAAA, 8'd3, 8'd3);
        send_lookup(8'd255, 21'd104, 8'd4, 8'd4);
        s_axis_tvalid <= 1'b0;
        // hold off until the atlas has answered everything
        @(posedge i_clk);
        while (pending != 0 || m_axis_tvalid) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
        for (int i = 0; i < RANDOM_LOOKUPS; i++) begin
            if (i == RANDOM_LOOKUPS / 3) begin
                send_idle_pct = 56;
                recv_idle_pct = 17;
            end else if (i == 2 * RANDOM_LOOKUPS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            send_random_lookup();
        end
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        $display("Sent %0d lookups: %0d hits, %0d no-room answers, under three stall mixes.",
                 lookups_sent, found_count, noroom_count);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_glyph_atlas_shelf_allocator_unit: PASS");
        end else begin
            $display("tb_glyph_atlas_shelf_allocator_unit: FAIL");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/gasa_pkg.sv
rtl/core/gasa_glyph_table.sv
rtl/core/gasa_shelf_table.sv
rtl/core/glyph_atlas_shelf_allocator_unit.sv
dv/glyph_atlas_shelf_allocator_checker.sv
dv/tb_glyph_atlas_shelf_allocator_unit.sv
